// ----- hdl/spsq_pkg.sv -----
// Shared types, constants and helper functions for the stepper phase sequencer.
`timescale 1ns / 1ps

package spsq_pkg;

    localparam int PHASE_COUNT  = 8;
    localparam int TICKS_PER_MS = 1000;

    localparam int STEPS_W  = 16;
    localparam int DRIVE_W  = 2;
    localparam int PERIOD_W = 24;
    localparam int MS_W     = 16;
    localparam int SINCE_W  = PERIOD_W + 1;
    localparam int WAIT_W   = 26;
    localparam int PHASE_W  = $clog2(PHASE_COUNT);
    localparam int COIL_W   = 4;

    localparam int TPM_W  = $clog2(TICKS_PER_MS + 1);
    localparam int PROD_W = (MS_W + TPM_W > WAIT_W) ? (MS_W + TPM_W) : (WAIT_W + 1);

    localparam logic [SINCE_W-1:0] SINCE_MAX = {SINCE_W{1'b1}};
    localparam logic [WAIT_W-1:0]  WAIT_MAX  = {WAIT_W{1'b1}};

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_MOVE = 1'b1;

    localparam logic DIR_FWD = 1'b0;

    localparam logic [DRIVE_W-1:0] DRIVE_WAVE = 2'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_FULL = 2'd1;
    localparam logic [DRIVE_W-1:0] DRIVE_HALF = 2'd2;

    localparam logic [COIL_W-1:0] WAVE_TBL [PHASE_COUNT] =
        '{4'h1, 4'h2, 4'h4, 4'h8, 4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [COIL_W-1:0] FULL_TBL [PHASE_COUNT] =
        '{4'h9, 4'h9, 4'h3, 4'h3, 4'h6, 4'h6, 4'hC, 4'hC};
    localparam logic [COIL_W-1:0] HALF_TBL [PHASE_COUNT] =
        '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

    // Input item after pre-decode: wait lengths in ticks, step threshold resolved.
    typedef struct packed {
        logic                req_type;
        logic [STEPS_W-1:0]  move_steps;
        logic [DRIVE_W-1:0]  drive_type;
        logic                move_direction;
        logic [SINCE_W-1:0]  need_ticks;
        logic [WAIT_W-1:0]   start_ticks;
        logic [WAIT_W-1:0]   end_ticks;
    } item_t;

    typedef struct packed {
        logic [COIL_W-1:0] coil_pattern;
        logic              busy_res;
        logic              move_done;
        logic              rejected;
    } result_t;

    // ms to ticks, saturated to the wait counter range
    function automatic logic [WAIT_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(ms) * PROD_W'(TICKS_PER_MS);
        if (prod > PROD_W'(WAIT_MAX))
            return WAIT_MAX;
        else
            return prod[WAIT_W-1:0];
    endfunction

    // Pattern for a phase; unused drive code keeps the current latch
    function automatic logic [COIL_W-1:0] coil_of(input logic [DRIVE_W-1:0] drive,
                                                   input logic [PHASE_W-1:0] phase,
                                                   input logic [COIL_W-1:0]  cur);
        logic [COIL_W-1:0] pat;
        unique case (drive)
            DRIVE_WAVE: pat = WAVE_TBL[phase];
            DRIVE_FULL: pat = FULL_TBL[phase];
            DRIVE_HALF: pat = HALF_TBL[phase];
            default:    pat = cur;
        endcase
        return pat;
    endfunction

endpackage

// ----- hdl/spsq_in_stage.sv -----
// Input register: takes one item, pre-decodes wait lengths and step threshold.
`timescale 1ns / 1ps

module spsq_in_stage
    import spsq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        s_tuser,
    output logic        item_valid,
    output item_t       item,
    input  logic        item_take
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic [PERIOD_W-1:0] period;

    assign s_tready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;
    assign period     = s_tdata[42:19];

    always_comb
    begin
        item_next.req_type       = s_tuser;
        item_next.move_steps     = s_tdata[15:0];
        item_next.drive_type     = s_tdata[17:16];
        item_next.move_direction = s_tdata[18];
        // wave drive runs at twice the period
        item_next.need_ticks     = (s_tdata[17:16] == DRIVE_WAVE) ? {period, 1'b0}
                                                                  : {1'b0, period};
        item_next.start_ticks    = ms_to_ticks(s_tdata[58:43]);
        item_next.end_ticks      = ms_to_ticks(s_tdata[74:59]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            item_reg  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                valid_reg <= 1'b1;
                item_reg  <= item_next;
            end
            else if (item_take)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/spsq_engine.sv -----
// Move sequencer state, per-item update and result register.
`timescale 1ns / 1ps

module spsq_engine
    import spsq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  item_t   item,
    output logic    item_take,
    output logic    res_valid,
    output result_t res,
    input  logic    res_ready
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_START = 2'd1,
        ST_STEP  = 2'd2,
        ST_END   = 2'd3
    } stage_t;

    stage_t               stage_reg, stage_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [COIL_W-1:0]    coil_reg, coil_next;
    logic [SINCE_W-1:0]   since_reg, since_next;
    logic [STEPS_W-1:0]   left_reg, left_next;
    logic [WAIT_W-1:0]    wait_reg, wait_next;
    logic [STEPS_W-1:0]   h_steps_reg, h_steps_next;
    logic [DRIVE_W-1:0]   h_drive_reg, h_drive_next;
    logic                 h_dir_reg, h_dir_next;
    logic [SINCE_W-1:0]   h_need_reg, h_need_next;
    logic [WAIT_W-1:0]    h_end_reg, h_end_next;
    logic                 out_valid_reg;
    result_t              out_reg, out_next;
    logic                 done, rej, do_step;

    assign item_take = item_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        stage_next   = stage_reg;
        phase_next   = phase_reg;
        coil_next    = coil_reg;
        since_next   = since_reg;
        left_next    = left_reg;
        wait_next    = wait_reg;
        h_steps_next = h_steps_reg;
        h_drive_next = h_drive_reg;
        h_dir_next   = h_dir_reg;
        h_need_next  = h_need_reg;
        h_end_next   = h_end_reg;
        done         = 1'b0;
        rej          = 1'b0;
        do_step      = 1'b0;

        if (item.req_type == REQ_MOVE)
        begin
            if (stage_reg != ST_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                h_steps_next = item.move_steps;
                h_drive_next = item.drive_type;
                h_dir_next   = item.move_direction;
                h_need_next  = item.need_ticks;
                h_end_next   = item.end_ticks;
                left_next    = item.move_steps;
                wait_next    = item.start_ticks;
                stage_next   = ST_START;
            end
        end
        else
        begin
            if (since_reg != SINCE_MAX)
                since_next = since_reg + 1'b1;

            if (stage_next == ST_START)
            begin
                if (wait_next != '0)
                    wait_next = wait_next - 1'b1;
                else
                    stage_next = ST_STEP;
            end
            // a stage may fall through to the next within one tick
            if (stage_next == ST_STEP)
            begin
                if (left_next == '0)
                begin
                    wait_next  = h_end_reg;
                    stage_next = ST_END;
                end
                else if (h_steps_reg == STEPS_W'(1))
                begin
                    do_step   = 1'b1;
                    left_next = '0;
                end
                else if (since_next >= h_need_reg)
                begin
                    do_step    = 1'b1;
                    left_next  = left_next - 1'b1;
                    since_next = '0;
                end
            end
            if (stage_next == ST_END)
            begin
                if (wait_next != '0)
                begin
                    wait_next = wait_next - 1'b1;
                end
                else
                begin
                    stage_next = ST_IDLE;
                    done       = 1'b1;
                end
            end

            if (do_step)
            begin
                coil_next = coil_of(h_drive_reg, phase_reg, coil_reg);
                if (h_dir_reg == DIR_FWD)
                    phase_next = phase_reg + 1'b1;
                else
                    phase_next = phase_reg - 1'b1;
            end
        end

        out_next.coil_pattern = coil_next;
        out_next.busy_res     = (stage_next != ST_IDLE);
        out_next.move_done    = done;
        out_next.rejected     = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= ST_IDLE;
            phase_reg     <= '0;
            coil_reg      <= '0;
            since_reg     <= '0;
            left_reg      <= '0;
            wait_reg      <= '0;
            h_steps_reg   <= '0;
            h_drive_reg   <= '0;
            h_dir_reg     <= 1'b0;
            h_need_reg    <= '0;
            h_end_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (item_take)
            begin
                stage_reg     <= stage_next;
                phase_reg     <= phase_next;
                coil_reg      <= coil_next;
                since_reg     <= since_next;
                left_reg      <= left_next;
                wait_reg      <= wait_next;
                h_steps_reg   <= h_steps_next;
                h_drive_reg   <= h_drive_next;
                h_dir_reg     <= h_dir_next;
                h_need_reg    <= h_need_next;
                h_end_reg     <= h_end_next;
                out_valid_reg <= 1'b1;
                out_reg       <= out_next;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/stepper_phase_sequencer_core.sv -----
// Top level of the stepper phase sequencer: input register, sequencer, result register.
//
//  channel | dir | handshake           | contents
//  --------+-----+---------------------+------------------------------------------
//  s_*     | in  | s_tvalid / s_tready | tick or move command item
//  m_*     | out | m_tvalid / m_tready | coil pattern and status, one per item
//
// One item per cycle sustained while m_tready is high; two register stages (input
// register, then the sequencer update into the result register), so the result
// shows on m_* once the sequencer update has loaded the result register.
// Reset clears the sequencer to idle, all coils off, phase 0.
// A stalled result holds; the input register still takes one item meanwhile,
// and s_tready drops only while both registers are full and m_tready is low.
`timescale 1ns / 1ps

module stepper_phase_sequencer_core
    import spsq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] move_steps, [17:16] drive_type, [18] move_direction,
    // [42:19] step_period_us, [58:43] start_wait_ms, [74:59] end_wait_ms, rest zero
    input  logic [79:0] s_tdata,
    // [0] req_type
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] coil_pattern, [4] busy_res, [5] move_done, [6] rejected, [7] zero
    output logic [7:0]  m_tdata
);

    logic    item_valid;
    item_t   item;
    logic    item_take;
    result_t res;

    spsq_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    spsq_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    assign m_tdata = {1'b0, res.rejected, res.move_done, res.busy_res, res.coil_pattern};

    // backpressure only when the result side is stalled
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while result side free");

    // a finished move reports idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res.move_done) |-> !res.busy_res)
        else $error("done pulse with busy set");

    // a rejected command cannot end a move
    a_rej_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(res.rejected && res.move_done))
        else $error("rejected and done together");

    // rejection only happens while a move is running
    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res.rejected) |-> res.busy_res)
        else $error("rejected while idle");

endmodule
